// ===== rtl/core/lphm_pkg.sv =====
// lphm_pkg: shared types and constants for the linear probe hash map core
// request and response payload structs, command, status and slot mark codes
// no dependencies
package lphm_pkg;

   localparam int unsigned HASH_BITS = 32;
   localparam int unsigned HCNT_BITS = $clog2(HASH_BITS);

   localparam logic [HASH_BITS-1:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [HASH_BITS-1:0] FNV_PRIME  = 32'd16777619;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_TOMB  = 2'd1;
   localparam logic [1:0] MARK_LIVE  = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [31:0] value_out;
      logic [8:0]  live_count;
   } rsp_type;

endpackage

// ===== rtl/core/lphm_ram.sv =====
// lphm_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module lphm_ram #(
   parameter int unsigned WIDTH = 66,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/linear_probe_hash_map_core.sv =====
// linear_probe_hash_map_core: open addressing key/value map with linear probing
// depends on lphm_pkg and lphm_ram
//
// usage:
//   req channel (req_valid, req_stall, req_data) takes one request: add, remove,
//   lookup or clear with a key and a value. rsp channel (rsp_valid, rsp_stall,
//   rsp_data) returns exactly one response per request, in order.
// request flow:
//   a request is taken in the idle state, hashed one key byte at a time
//   (ceil(KEY_BITS/8) bytes) in the fnv-1a multiplier, reduced to a home slot
//   (bit-serially over the hash bits when SLOTS is not a power of two), then
//   probed slot by slot on the slot ram read port; last the response register
//   is loaded and the core returns to idle.
//   one request is in flight at a time; the next one is taken while the
//   previous response still waits in the output register.
// reset and clear:
//   after reset the slot ram marks are swept to empty, one slot at a time,
//   while req_stall is high. a clear request runs the same sweep.
// stall:
//   a stalled response holds in the output register; the core finishes the
//   next request and then waits until the register is free.
module linear_probe_hash_map_core #(
   parameter int unsigned SLOTS      = 256,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lphm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lphm_pkg::rsp_type rsp_data
);

   import lphm_pkg::*;

   localparam int unsigned AW     = $clog2(SLOTS);
   localparam int unsigned CW     = $clog2(SLOTS + 1);
   localparam int unsigned KW     = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int unsigned VW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int unsigned MW     = 2 + KW + VW;
   localparam int unsigned NBYTES = (KEY_BITS + 7) / 8;
   localparam int unsigned BCW    = (NBYTES > 1) ? $clog2(NBYTES) : 1;
   localparam bit          POW2   = (SLOTS & (SLOTS - 1)) == 0;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_MOD,
      S_PROBE,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [KW-1:0]        key_ff, key_in;
   logic [VW-1:0]        val_ff, val_in;
   logic [HASH_BITS-1:0] h_ff, h_in;
   logic [BCW-1:0]       bcnt_ff, bcnt_in;
   logic [HCNT_BITS-1:0] mcnt_ff, mcnt_in;
   logic [AW-1:0]        rem_ff, rem_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [AW-1:0]        chk_addr_ff, chk_addr_in;
   logic [AW-1:0]        chk_cnt_ff, chk_cnt_in;
   logic                 pend_ff, pend_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   logic [VW-1:0]        res_value_ff, res_value_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [MW-1:0]        ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [MW-1:0]        ram_rdata;

   logic [1:0]           rd_mark;
   logic [KW-1:0]        rd_key;
   logic [VW-1:0]        rd_val;
   logic [63:0]          key_wide;
   logic [7:0]           key_byte;
   logic [HASH_BITS-1:0] hash_step;
   logic [AW:0]          rem_sh;
   logic [AW:0]          rem_nx;
   logic [AW-1:0]        addr_inc;
   logic [CW+8:0]        cnt_wide;
   logic                 rd_empty;
   logic                 rd_match;
   logic                 last_probe;

   lphm_ram #(
      .WIDTH(MW),
      .DEPTH(SLOTS)
   ) u_slots (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd_mark    = ram_rdata[MW-1 -: 2];
   assign rd_key     = ram_rdata[KW+VW-1 -: KW];
   assign rd_val     = ram_rdata[VW-1:0];
   assign rd_empty   = rd_mark == MARK_EMPTY;
   assign rd_match   = (rd_mark == MARK_LIVE) && (rd_key == key_ff);
   assign last_probe = chk_cnt_ff == AW'(SLOTS - 1);

   assign key_wide  = 64'(key_ff);
   assign key_byte  = 8'(key_wide >> {bcnt_ff, 3'b000});
   assign hash_step = HASH_BITS'((h_ff ^ HASH_BITS'(key_byte)) * FNV_PRIME);

   assign rem_sh   = {rem_ff, h_ff[HASH_BITS-1]};
   assign rem_nx   = (rem_sh >= (AW+1)'(SLOTS)) ? rem_sh - (AW+1)'(SLOTS) : rem_sh;
   assign addr_inc = (addr_ff == AW'(SLOTS - 1)) ? '0 : addr_ff + AW'(1);
   assign cnt_wide = (CW+9)'(cnt_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      h_in          = h_ff;
      bcnt_in       = bcnt_ff;
      mcnt_in       = mcnt_ff;
      rem_in        = rem_ff;
      addr_in       = addr_ff;
      chk_addr_in   = chk_addr_ff;
      chk_cnt_in    = chk_cnt_ff;
      pend_in       = pend_ff;
      cnt_in        = cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = chk_addr_ff;
      ram_wdata     = {MARK_LIVE, key_ff, val_ff};
      ram_raddr     = addr_ff;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = {MARK_EMPTY, {(KW+VW){1'b0}}};
            if (addr_ff == AW'(SLOTS - 1)) begin
               state_in = clr_rsp_ff ? S_RESP : S_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_data.cmd;
               key_in        = req_data.key[KW-1:0];
               val_in        = req_data.value_in[VW-1:0];
               res_status_in = STATUS_OK;
               res_found_in  = 1'b0;
               res_value_in  = '0;
               if (req_data.cmd == CMD_CLEAR) begin
                  cnt_in     = '0;
                  addr_in    = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end else begin
                  h_in     = FNV_OFFSET;
                  bcnt_in  = '0;
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            h_in    = hash_step;
            bcnt_in = bcnt_ff + BCW'(1);
            if (bcnt_ff == BCW'(NBYTES - 1)) begin
               mcnt_in  = '0;
               rem_in   = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            pend_in    = 1'b0;
            chk_cnt_in = '0;
            if (POW2) begin
               addr_in  = h_ff[AW-1:0];
               state_in = S_PROBE;
            end else begin
               rem_in  = rem_nx[AW-1:0];
               h_in    = h_ff << 1;
               mcnt_in = mcnt_ff + HCNT_BITS'(1);
               if (mcnt_ff == HCNT_BITS'(HASH_BITS - 1)) begin
                  addr_in  = rem_nx[AW-1:0];
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            addr_in     = addr_inc;
            chk_addr_in = addr_ff;
            pend_in     = 1'b1;
            if (pend_ff) begin
               chk_cnt_in = chk_cnt_ff + AW'(1);
               case (cmd_ff)
                  CMD_ADD: begin
                     if (rd_empty || rd_match) begin
                        ram_we       = 1'b1;
                        res_found_in = rd_match;
                        if (rd_empty) begin
                           cnt_in = cnt_ff + CW'(1);
                        end
                        pend_in  = 1'b0;
                        state_in = S_RESP;
                     end else if (last_probe) begin
                        res_status_in = STATUS_FULL;
                        pend_in       = 1'b0;
                        state_in      = S_RESP;
                     end
                  end
                  CMD_REMOVE, CMD_LOOKUP: begin
                     if (rd_match) begin
                        res_found_in = 1'b1;
                        if (cmd_ff == CMD_REMOVE) begin
                           ram_we    = 1'b1;
                           ram_wdata = {MARK_TOMB, rd_key, rd_val};
                           if (cnt_ff != '0) begin
                              cnt_in = cnt_ff - CW'(1);
                           end
                        end else begin
                           res_value_in = rd_val;
                        end
                        pend_in  = 1'b0;
                        state_in = S_RESP;
                     end else if (rd_empty || last_probe) begin
                        res_status_in = STATUS_MISS;
                        pend_in       = 1'b0;
                        state_in      = S_RESP;
                     end
                  end
                  default: begin
                     pend_in  = 1'b0;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = res_status_ff;
               rsp_data_in.found      = res_found_ff;
               rsp_data_in.value_out  = 32'(res_value_ff);
               rsp_data_in.live_count = cnt_wide[8:0];
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      h_ff          <= h_in;
      bcnt_ff       <= bcnt_in;
      mcnt_ff       <= mcnt_in;
      rem_ff        <= rem_in;
      chk_addr_ff   <= chk_addr_in;
      chk_cnt_ff    <= chk_cnt_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_value_ff  <= res_value_in;
      rsp_data_ff   <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(SLOTS))
      else $error("live entry count above table size");

   a_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_PROBE))
      else $error("slot ram written outside sweep or probe");

   a_probe_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && $past(state_ff) == S_PROBE)
         |-> chk_addr_ff == $past(addr_ff))
      else $error("checked slot does not match issued read");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && rsp_stall) |=> state_ff == S_RESP)
      else $error("response left while output register was full");

endmodule
